[rtl/fbsa_pkg.sv]
// Shared types, constants and sequencer states of the fixed block stack allocator.
package fbsa_pkg;

  localparam int BLOCK_BYTES_DEFAULT = 8 * 1024;
  localparam int LIST_DEPTH_DEFAULT  = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SIZE  = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_SPACE = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic REG_TOP   = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } in_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [2:0]  status;
  } out_t;

  typedef struct packed {
    logic        top_load;
    logic [31:0] region_top;
    logic [31:0] region_floor;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_t;

endpackage

[rtl/fbsa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module fbsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/fbsa_seq.sv]
// Sequencer and datapath: free list ring, carve pointer and the duplicate scan.
module fbsa_seq #(
  parameter int BLOCK_BYTES = fbsa_pkg::BLOCK_BYTES_DEFAULT,
  parameter int LIST_DEPTH  = fbsa_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  fbsa_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  fbsa_pkg::in_t  in_item,
  output logic           res_valid,
  input  logic           res_take,
  output fbsa_pkg::out_t res
);

  import fbsa_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
  localparam logic [31:0]      BLOCK_SZ = 32'(BLOCK_BYTES);

  state_t state, state_next;
  in_t item, item_next;
  logic [IDX_W-1:0] head, head_next, tail, tail_next, pos, pos_next, pos_inc;
  logic [CNT_W-1:0] count, count_next, scan_k, scan_k_next;
  logic [31:0] carve, carve_next, carve_dec;
  out_t res_next;

  logic rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0] rd_data;
  logic size_bad, carve_low;

  fbsa_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_list (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (item.free_address),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pos_inc   = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  assign carve_dec = carve - BLOCK_SZ;
  assign size_bad  = (item.request_size < 32'd4) || (item.request_size > BLOCK_SZ);
  assign carve_low = (carve < BLOCK_SZ) || (carve_dec < cfg.region_floor);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      carve <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      carve <= cfg.top_load ? cfg.region_top : carve_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    pos    <= pos_next;
    scan_k <= scan_k_next;
    res    <= res_next;
  end

  always_comb begin
    state_next  = state;
    item_next   = item;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    carve_next  = carve;
    pos_next    = pos;
    scan_k_next = scan_k;
    res_next    = res;
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_en       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next  = in_item;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_next.block_address = '0;
        res_next.status        = ST_OK;
        if (item.mode == MODE_ALLOC) begin
          if (size_bad) begin
            res_next.status = ST_SIZE;
            state_next      = S_RESP;
          end else if (count != '0) begin
            rd_en      = 1'b1;
            state_next = S_POP;
          end else if (carve_low) begin
            res_next.status = ST_SPACE;
            state_next      = S_RESP;
          end else begin
            carve_next             = carve_dec;
            res_next.block_address = carve_dec;
            state_next             = S_RESP;
          end
        end else begin
          if (count == '0) begin
            state_next = S_UPDATE;
          end else begin
            rd_en       = 1'b1;
            pos_next    = head;
            scan_k_next = '0;
            state_next  = S_SCAN;
          end
        end
      end
      S_POP: begin
        res_next.block_address = rd_data;
        res_next.status        = ST_OK;
        head_next              = (head == LAST_IDX) ? '0 : head + 1'b1;
        count_next             = count - 1'b1;
        state_next             = S_RESP;
      end
      S_SCAN: begin
        if (rd_data == item.free_address) begin
          res_next.block_address = '0;
          res_next.status        = ST_DUP;
          state_next             = S_RESP;
        end else if (CNT_W'(scan_k + 1'b1) == count) begin
          state_next = S_UPDATE;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = pos_inc;
          pos_next    = pos_inc;
          scan_k_next = CNT_W'(scan_k + 1'b1);
        end
      end
      S_UPDATE: begin
        res_next.block_address = '0;
        state_next             = S_RESP;
        if (count == FULL_CNT) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status = ST_OK;
          wr_en           = 1'b1;
          tail_next       = (tail == LAST_IDX) ? '0 : tail + 1'b1;
          count_next      = count + 1'b1;
        end
      end
      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/fixed_block_stack_allocator.sv]
// Top level of the fixed block stack allocator: register port, sequencer and output register.
// A rejected or carved allocate goes from the decide state straight to the response state;
// an allocate reusing a listed block passes the pop state first. A free walks the live free
// list entries in the scan state, if any, then passes the update state unless the scan finds
// a duplicate. The duplicate scan reads one list entry per cycle from the free list RAM and
// compares it in a single 32-bit comparator. One item is in work at a time, and the next
// item can be accepted in the cycle after the previous result moves into the output register,
// also while that result still waits there. A region_top write also reloads the carve pointer.
module fixed_block_stack_allocator #(
  parameter int BLOCK_BYTES = fbsa_pkg::BLOCK_BYTES_DEFAULT,
  parameter int LIST_DEPTH  = fbsa_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid,
  output logic           in_stall,
  input  fbsa_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output fbsa_pkg::out_t out_item
);

  import fbsa_pkg::*;

  logic [31:0] region_top, region_floor;
  logic        wr_hit, res_valid, res_take;
  cfg_t        cfg;
  out_t        res;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_top   <= '0;
      region_floor <= '0;
    end else if (wr_hit) begin
      if (paddr[2] == REG_TOP) begin
        region_top <= pwdata;
      end else begin
        region_floor <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_TOP) ? region_top : region_floor;

  always_comb begin
    cfg.top_load     = wr_hit && (paddr[2] == REG_TOP);
    cfg.region_top   = pwdata;
    cfg.region_floor = region_floor;
  end

  fbsa_seq #(.BLOCK_BYTES(BLOCK_BYTES), .LIST_DEPTH(LIST_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res;
    end
  end

endmodule
